FILE: hw/rtl/sst_pkg.sv
// ----------------------------------------------------------------------------
// sst_pkg
// Shared types and constants of the render-state shadow tracker.
// ----------------------------------------------------------------------------
package sst_pkg;

  localparam int NUM_SLOTS_DEF = 19;
  localparam int IDX_W         = 5;
  localparam int HASH_W        = 64;
  localparam int CNT_W         = 32;
  localparam int CFG_IDX_W     = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_VALIDATE_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRACK_REDUNDANT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REQUIRED_MASK   = 2'd2;

  typedef enum logic [2:0] {
    OP_WRITE        = 3'd0,
    OP_INVAL_ONE    = 3'd1,
    OP_INVAL_ALL    = 3'd2,
    OP_VALIDATE     = 3'd3,
    OP_CLEAR_COUNTS = 3'd4,
    OP_QUERY        = 3'd5,
    OP_RESET_ALL    = 3'd6,
    OP_STATS        = 3'd7
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [IDX_W-1:0]  index;
    logic [HASH_W-1:0] hash;
  } cmd_t;

  typedef struct packed {
    logic             draw_ok;
    logic             slot_valid;
    logic [CNT_W-1:0] slot_writes;
    logic [CNT_W-1:0] slot_redundant;
    logic [CNT_W-1:0] total_writes;
    logic [CNT_W-1:0] total_redundant;
    logic [CNT_W-1:0] failed_draws;
    logic [CNT_W-1:0] checked_draws;
  } result_t;

endpackage

FILE: hw/rtl/state_shadow_tracker_unit.sv
// ----------------------------------------------------------------------------
// state_shadow_tracker_unit
// Render-state shadow table: command register, slot table, result register.
// ----------------------------------------------------------------------------
// done follows start through the command register, then the table update and
// result register.
// Throughput: one command per cycle; busy is never asserted.
// Reset invalidates all slots and clears all counters; validation and redundant
// tracking come up enabled, required mask zero. The receiver cannot stall.
module state_shadow_tracker_unit #(
  parameter int  NUM_SLOTS = sst_pkg::NUM_SLOTS_DEF,
  localparam int VCNT_W    = $clog2(NUM_SLOTS + 1)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [2:0]                     opcode,
  input  logic [sst_pkg::IDX_W-1:0]      state_index,
  input  logic [sst_pkg::HASH_W-1:0]     value_hash,
  input  logic                           cfg_we,
  input  logic [sst_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [NUM_SLOTS-1:0]           cfg_data,
  output logic                           done,
  output logic                           draw_ok,
  output logic [NUM_SLOTS-1:0]           missing_mask,
  output logic                           slot_valid,
  output logic [sst_pkg::CNT_W-1:0]      slot_writes,
  output logic [sst_pkg::CNT_W-1:0]      slot_redundant,
  output logic [sst_pkg::CNT_W-1:0]      total_writes,
  output logic [sst_pkg::CNT_W-1:0]      total_redundant,
  output logic [sst_pkg::CNT_W-1:0]      failed_draws,
  output logic [sst_pkg::CNT_W-1:0]      checked_draws,
  output logic [VCNT_W-1:0]              valid_slots
);
  import sst_pkg::*;

  logic                 cmd_valid;
  cmd_t                 cmd;
  result_t              result;
  logic [NUM_SLOTS-1:0] missing_next;
  logic [VCNT_W-1:0]    count_next;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      cmd_valid <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cmd <= '{op: op_t'(opcode), index: state_index, hash: value_hash};
    end
  end

  sst_slot_table #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_table (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_data     (cfg_data),
    .result       (result),
    .missing_next (missing_next),
    .count_next   (count_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid) begin
      draw_ok         <= result.draw_ok;
      missing_mask    <= missing_next;
      slot_valid      <= result.slot_valid;
      slot_writes     <= result.slot_writes;
      slot_redundant  <= result.slot_redundant;
      total_writes    <= result.total_writes;
      total_redundant <= result.total_redundant;
      failed_draws    <= result.failed_draws;
      checked_draws   <= result.checked_draws;
      valid_slots     <= count_next;
    end
  end

endmodule

FILE: hw/rtl/sst_slot_table.sv
// ----------------------------------------------------------------------------
// sst_slot_table
// Slot table, global counters and configuration registers. Decodes one
// registered command, updates the state and forms the post-command result.
// ----------------------------------------------------------------------------
module sst_slot_table #(
  parameter int  NUM_SLOTS = sst_pkg::NUM_SLOTS_DEF,
  localparam int VCNT_W    = $clog2(NUM_SLOTS + 1)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cmd_valid,
  input  sst_pkg::cmd_t                  cmd,
  input  logic                           cfg_we,
  input  logic [sst_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [NUM_SLOTS-1:0]           cfg_data,
  output sst_pkg::result_t               result,
  output logic [NUM_SLOTS-1:0]           missing_next,
  output logic [VCNT_W-1:0]              count_next
);
  import sst_pkg::*;

  localparam int SEL_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  logic                 validate_enable;
  logic                 track_redundant;
  logic [NUM_SLOTS-1:0] required_mask;
  logic [NUM_SLOTS-1:0] valid_bits;
  logic [HASH_W-1:0]    slot_hash   [NUM_SLOTS];
  logic [CNT_W-1:0]     write_count [NUM_SLOTS];
  logic [CNT_W-1:0]     red_count   [NUM_SLOTS];
  logic [CNT_W-1:0]     total_writes;
  logic [CNT_W-1:0]     total_redundant;
  logic [CNT_W-1:0]     failed_draws;
  logic [CNT_W-1:0]     checked_draws;

  logic do_write, do_inval_one, do_inval_all, do_validate, do_clear, do_reset;
  logic                 in_range;
  logic [SEL_W-1:0]     sel;
  logic                 cur_valid;
  logic [CNT_W-1:0]     cur_writes;
  logic [CNT_W-1:0]     cur_red;
  logic                 hit_write;
  logic                 redundant;
  logic                 draw_fail;
  logic [NUM_SLOTS-1:0] valid_next;
  logic [NUM_SLOTS-1:0] req_after;
  logic [NUM_SLOTS-1:0] required_mask_next;
  logic [NUM_SLOTS-1:0] missing_now;
  logic [CNT_W-1:0]     slot_writes_next;
  logic [CNT_W-1:0]     slot_red_next;
  logic [CNT_W-1:0]     total_writes_next;
  logic [CNT_W-1:0]     total_redundant_next;
  logic [CNT_W-1:0]     failed_draws_next;
  logic [CNT_W-1:0]     checked_draws_next;

  always_comb begin
    do_write     = 1'b0;
    do_inval_one = 1'b0;
    do_inval_all = 1'b0;
    do_validate  = 1'b0;
    do_clear     = 1'b0;
    do_reset     = 1'b0;
    if (cmd_valid) begin
      unique case (cmd.op)
        OP_WRITE:           do_write     = 1'b1;
        OP_INVAL_ONE:       do_inval_one = 1'b1;
        OP_INVAL_ALL:       do_inval_all = 1'b1;
        OP_VALIDATE:        do_validate  = 1'b1;
        OP_CLEAR_COUNTS:    do_clear     = 1'b1;
        OP_RESET_ALL:       do_reset     = 1'b1;
        OP_QUERY, OP_STATS: ;
        default:            ;
      endcase
    end
  end

  assign in_range   = ({1'b0, cmd.index} < (IDX_W + 1)'(NUM_SLOTS));
  assign sel        = cmd.index[SEL_W-1:0];
  assign cur_valid  = in_range & valid_bits[sel];
  assign cur_writes = in_range ? write_count[sel] : '0;
  assign cur_red    = in_range ? red_count[sel] : '0;
  assign hit_write  = do_write & in_range;
  assign redundant  = hit_write & track_redundant & cur_valid & (slot_hash[sel] == cmd.hash);

  always_comb begin
    valid_next = valid_bits;
    if (do_inval_all || do_reset) begin
      valid_next = '0;
    end
    if (hit_write) begin
      valid_next[sel] = 1'b1;
    end
    if (do_inval_one && in_range) begin
      valid_next[sel] = 1'b0;
    end
  end

  assign slot_writes_next = (do_clear || do_reset) ? '0 :
                            hit_write ? cur_writes + 1'b1 : cur_writes;
  assign slot_red_next    = (do_clear || do_reset) ? '0 :
                            redundant ? cur_red + 1'b1 : cur_red;

  assign req_after    = do_reset ? '0 : required_mask;
  assign required_mask_next = (cfg_we && cfg_idx == CFG_REQUIRED_MASK) ? cfg_data : req_after;
  assign missing_now  = required_mask & ~valid_bits;
  assign missing_next = req_after & ~valid_next;
  assign draw_fail    = do_validate & validate_enable & (missing_now != '0);

  assign total_writes_next    = do_reset ? '0 : hit_write ? total_writes + 1'b1 : total_writes;
  assign total_redundant_next = do_reset ? '0 :
                                redundant ? total_redundant + 1'b1 : total_redundant;
  assign failed_draws_next    = do_reset ? '0 : draw_fail ? failed_draws + 1'b1 : failed_draws;
  assign checked_draws_next   = do_reset ? '0 :
                                do_validate ? checked_draws + 1'b1 : checked_draws;

  always_comb begin
    count_next = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      count_next = count_next + VCNT_W'(valid_next[i]);
    end
  end

  always_comb begin
    result.draw_ok         = do_validate & ~draw_fail;
    result.slot_valid      = in_range & valid_next[sel];
    result.slot_writes     = in_range ? slot_writes_next : '0;
    result.slot_redundant  = in_range ? slot_red_next : '0;
    result.total_writes    = total_writes_next;
    result.total_redundant = total_redundant_next;
    result.failed_draws    = failed_draws_next;
    result.checked_draws   = checked_draws_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      validate_enable <= 1'b1;
      track_redundant <= 1'b1;
      required_mask   <= '0;
      valid_bits      <= '0;
      total_writes    <= '0;
      total_redundant <= '0;
      failed_draws    <= '0;
      checked_draws   <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        write_count[i] <= '0;
        red_count[i]   <= '0;
      end
    end else begin
      required_mask   <= required_mask_next;
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_VALIDATE_ENABLE: validate_enable <= cfg_data[0];
          CFG_TRACK_REDUNDANT: track_redundant <= cfg_data[0];
          CFG_REQUIRED_MASK:   ;
          default:             ;
        endcase
      end
      valid_bits      <= valid_next;
      total_writes    <= total_writes_next;
      total_redundant <= total_redundant_next;
      failed_draws    <= failed_draws_next;
      checked_draws   <= checked_draws_next;
      if (do_clear || do_reset) begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          write_count[i] <= '0;
          red_count[i]   <= '0;
        end
      end else if (hit_write) begin
        write_count[sel] <= slot_writes_next;
        red_count[sel]   <= slot_red_next;
      end
    end
  end

  // hash is only compared while the slot is valid
  always_ff @(posedge clk) begin
    if (hit_write) begin
      slot_hash[sel] <= cmd.hash;
    end
  end

  a_write_counts: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd.op == OP_WRITE && in_range |=> total_writes == $past(total_writes) + 1'b1)
    else $error("total write count did not advance on an in-range write");

  a_failed_hold: assert property (@(posedge clk) disable iff (rst)
    !do_validate && !do_reset |=> $stable(failed_draws))
    else $error("failed draw count moved without a validate");

  a_query_quiet: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && (cmd.op == OP_QUERY || cmd.op == OP_STATS)
      |=> $stable(valid_bits) && $stable(total_writes) && $stable(checked_draws))
    else $error("query or stats changed the table");

  a_draw_ok: assert property (@(posedge clk) disable iff (rst)
    result.draw_ok |-> (missing_now == '0 || !validate_enable))
    else $error("draw passed with required slots missing");

endmodule

FILE: bench/state_shadow_tracker_checker.sv
// ----------------------------------------------------------------------------
// state_shadow_tracker_checker
// Watches the command, config and result channels of the shadow tracker,
// keeps its own copy of the slot table and counters, predicts one result per
// accepted transaction and compares each strobed result field by field.
// ----------------------------------------------------------------------------
module state_shadow_tracker_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic [2:0]                    opcode,
  input  logic [sst_pkg::IDX_W-1:0]     state_index,
  input  logic [sst_pkg::HASH_W-1:0]    value_hash,
  input  logic                          cfg_we,
  input  logic [sst_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [18:0]                   cfg_data,
  input  logic                          done,
  input  logic                          draw_ok,
  input  logic [18:0]                   missing_mask,
  input  logic                          slot_valid,
  input  logic [sst_pkg::CNT_W-1:0]     slot_writes,
  input  logic [sst_pkg::CNT_W-1:0]     slot_redundant,
  input  logic [sst_pkg::CNT_W-1:0]     total_writes,
  input  logic [sst_pkg::CNT_W-1:0]     total_redundant,
  input  logic [sst_pkg::CNT_W-1:0]     failed_draws,
  input  logic [sst_pkg::CNT_W-1:0]     checked_draws,
  input  logic [4:0]                    valid_slots,
  output int                            errors,
  output int                            outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import sst_pkg::*;

  localparam int NSLOT = NUM_SLOTS_DEF;

  typedef struct packed {
    logic             draw_ok;
    logic [18:0]      missing;
    logic             slot_valid;
    logic [CNT_W-1:0] slot_writes;
    logic [CNT_W-1:0] slot_redundant;
    logic [CNT_W-1:0] total_writes;
    logic [CNT_W-1:0] total_redundant;
    logic [CNT_W-1:0] failed_draws;
    logic [CNT_W-1:0] checked_draws;
    logic [4:0]       valid_slots;
  } tracker_result_t;

  // shadow copy of the table and config
  logic              check_en;
  logic              track_red;
  logic [NSLOT-1:0]  req_mask;
  logic [NSLOT-1:0]  shadow_valid;
  logic [HASH_W-1:0] shadow_hash [NSLOT];
  logic [CNT_W-1:0]  slot_wr_cnt [NSLOT];
  logic [CNT_W-1:0]  slot_red_cnt [NSLOT];
  logic [CNT_W-1:0]  writes_total, redundant_total, fail_total, draw_total;

  tracker_result_t expected_results [$];

  initial begin
    errors = 0;
    outstanding = 0;
  end

  function automatic void clear_table();
    shadow_valid = '0;
    for (int i = 0; i < NSLOT; i++) begin
      shadow_hash[i] = '0;
      slot_wr_cnt[i] = '0;
      slot_red_cnt[i] = '0;
    end
    writes_total = '0;
    redundant_total = '0;
    fail_total = '0;
    draw_total = '0;
  endfunction

  function automatic tracker_result_t apply_command(op_t op, logic [IDX_W-1:0] idx,
                                                    logic [HASH_W-1:0] hash);
    tracker_result_t r;
    logic in_range;
    r = '0;
    in_range = idx < NSLOT;
    case (op)
      OP_WRITE: begin
        if (in_range) begin
          if (track_red && shadow_valid[idx] && shadow_hash[idx] == hash) begin
            slot_red_cnt[idx] = slot_red_cnt[idx] + 1;
            redundant_total = redundant_total + 1;
          end
          shadow_hash[idx] = hash;
          shadow_valid[idx] = 1'b1;
          slot_wr_cnt[idx] = slot_wr_cnt[idx] + 1;
          writes_total = writes_total + 1;
        end
      end
      OP_INVAL_ONE: begin
        if (in_range) shadow_valid[idx] = 1'b0;
      end
      OP_INVAL_ALL: shadow_valid = '0;
      OP_VALIDATE: begin
        draw_total = draw_total + 1;
        if (!check_en) begin
          r.draw_ok = 1'b1;
        end else if ((req_mask & ~shadow_valid) != '0) begin
          fail_total = fail_total + 1;
        end else begin
          r.draw_ok = 1'b1;
        end
      end
      OP_CLEAR_COUNTS: begin
        for (int i = 0; i < NSLOT; i++) begin
          slot_wr_cnt[i] = '0;
          slot_red_cnt[i] = '0;
        end
      end
      OP_RESET_ALL: begin
        clear_table();
        req_mask = '0;
      end
      default: ;
    endcase
    r.missing = req_mask & ~shadow_valid;
    if (in_range) begin
      r.slot_valid = shadow_valid[idx];
      r.slot_writes = slot_wr_cnt[idx];
      r.slot_redundant = slot_red_cnt[idx];
    end
    r.total_writes = writes_total;
    r.total_redundant = redundant_total;
    r.failed_draws = fail_total;
    r.checked_draws = draw_total;
    r.valid_slots = 5'($countones(shadow_valid));
    return r;
  endfunction

  task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= 10)
        $display("%0t: %s differs: expected %0h, got %0h", $realtime, name, want, got);
    end
  endtask

  always @(posedge clk) begin : track
    tracker_result_t want;
    if (rst) begin
      check_en = 1'b1;
      track_red = 1'b1;
      req_mask = '0;
      clear_table();
      expected_results.delete();
    end else begin
      if (done) begin
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10) $display("%0t: result strobe with no transaction pending", $realtime);
        end else begin
          want = expected_results.pop_front();
          compare_field("draw_ok", want.draw_ok, draw_ok);
          compare_field("missing_mask", want.missing, missing_mask);
          compare_field("slot_valid", want.slot_valid, slot_valid);
          compare_field("slot_writes", want.slot_writes, slot_writes);
          compare_field("slot_redundant", want.slot_redundant, slot_redundant);
          compare_field("total_writes", want.total_writes, total_writes);
          compare_field("total_redundant", want.total_redundant, total_redundant);
          compare_field("failed_draws", want.failed_draws, failed_draws);
          compare_field("checked_draws", want.checked_draws, checked_draws);
          compare_field("valid_slots", want.valid_slots, valid_slots);
        end
      end
      if (cfg_we) begin
        case (cfg_idx)
          CFG_VALIDATE_ENABLE: check_en = cfg_data[0];
          CFG_TRACK_REDUNDANT: track_red = cfg_data[0];
          CFG_REQUIRED_MASK:   req_mask = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy)
        expected_results.insert(expected_results.size(),
                                apply_command(op_t'(opcode), state_index, value_hash));
    end
    outstanding <= expected_results.size();
  end

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the render-state shadow tracker: directed commands covering
// index range, redundant writes, invalidation, draw checks and resets, then
// random command streams under several configs, mostly with random idle gaps.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sst_pkg::*;

  localparam int NSLOT = NUM_SLOTS_DEF;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic [2:0]           opcode = OP_QUERY;
  logic [IDX_W-1:0]     state_index = '0;
  logic [HASH_W-1:0]    value_hash = '0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = CFG_VALIDATE_ENABLE;
  logic [18:0]          cfg_data = '0;

  logic                 busy, done, draw_ok, slot_valid;
  logic [18:0]          missing_mask;
  logic [CNT_W-1:0]     slot_writes, slot_redundant, total_writes, total_redundant;
  logic [CNT_W-1:0]     failed_draws, checked_draws;
  logic [4:0]           valid_slots;
  int                   errors, outstanding;

  int sent = 0;
  bit idle_on = 1'b1;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  state_shadow_tracker_unit dut (
    .clk, .rst, .start, .busy, .opcode, .state_index, .value_hash,
    .cfg_we, .cfg_idx, .cfg_data, .done, .draw_ok, .missing_mask,
    .slot_valid, .slot_writes, .slot_redundant, .total_writes,
    .total_redundant, .failed_draws, .checked_draws, .valid_slots
  );

  state_shadow_tracker_checker tracker_check (
    .clk, .rst, .start, .busy, .opcode, .state_index, .value_hash,
    .cfg_we, .cfg_idx, .cfg_data, .done, .draw_ok, .missing_mask,
    .slot_valid, .slot_writes, .slot_redundant, .total_writes,
    .total_redundant, .failed_draws, .checked_draws, .valid_slots,
    .errors, .outstanding
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 4);
  endfunction

  function automatic logic [HASH_W-1:0] pick_hash();
    logic [HASH_W-1:0] pool [4];
    pool[0] = '0;
    pool[1] = '1;
    pool[2] = 64'h0123_4567_89AB_CDEF;
    pool[3] = 64'h8000_0000_0000_0001;
    if ($urandom_range(9) < 6) return pool[$urandom_range(3)];
    return {$urandom, $urandom};
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    if ($urandom_range(99) < 85) return IDX_W'($urandom_range(NSLOT - 1));
    return IDX_W'($urandom_range(31, NSLOT));
  endfunction

  function automatic logic [18:0] pick_mask();
    case ($urandom_range(3))
      0: return '1;
      1: return 19'(1) << $urandom_range(NSLOT - 1);
      default: return 19'($urandom);
    endcase
  endfunction

  task automatic issue(input op_t op, input logic [IDX_W-1:0] idx,
                       input logic [HASH_W-1:0] hash);
    int gap;
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    opcode <= op;
    state_index <= idx;
    value_hash <= hash;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [18:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic program_config(input bit en, input bit trk, input logic [18:0] mask);
    write_reg(CFG_VALIDATE_ENABLE, {18'($urandom), en});
    write_reg(CFG_TRACK_REDUNDANT, {18'($urandom), trk});
    write_reg(CFG_REQUIRED_MASK, mask);
    cfg_we <= 1'b0;
  endtask

  task automatic random_command();
    int sel;
    sel = $urandom_range(99);
    if (sel < 4) begin
      // fill every slot so that full-mask draws can pass
      for (int s = 0; s < NSLOT; s++) issue(OP_WRITE, IDX_W'(s), pick_hash());
    end else if (sel < 48) issue(OP_WRITE, pick_index(), pick_hash());
    else if (sel < 58) issue(OP_INVAL_ONE, pick_index(), pick_hash());
    else if (sel < 61) issue(OP_INVAL_ALL, pick_index(), pick_hash());
    else if (sel < 77) issue(OP_VALIDATE, pick_index(), pick_hash());
    else if (sel < 80) issue(OP_CLEAR_COUNTS, pick_index(), pick_hash());
    else if (sel < 93) issue(OP_QUERY, pick_index(), pick_hash());
    else if (sel < 94) issue(OP_RESET_ALL, pick_index(), pick_hash());
    else issue(OP_STATS, pick_index(), pick_hash());
  endtask

  initial begin
    int phase_end;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: slots 0 and 18 required
    write_reg(CFG_SPARE, 19'($urandom));
    program_config(1'b1, 1'b1, 19'h40001);
    issue(OP_WRITE, 5'd0, '0);
    issue(OP_WRITE, 5'd0, '0);
    issue(OP_WRITE, 5'd18, '1);
    issue(OP_WRITE, 5'd18, '1);
    issue(OP_WRITE, 5'd19, 64'hDEAD_BEEF_0000_0001);
    issue(OP_WRITE, 5'd31, '1);
    issue(OP_VALIDATE, 5'd0, '0);
    issue(OP_INVAL_ONE, 5'd0, '0);
    issue(OP_INVAL_ONE, 5'd31, '0);
    issue(OP_VALIDATE, 5'd0, '0);
    issue(OP_WRITE, 5'd0, '0);
    issue(OP_QUERY, 5'd0, '0);
    issue(OP_QUERY, 5'd18, '1);
    issue(OP_QUERY, 5'd31, '0);
    issue(OP_INVAL_ALL, 5'd7, '0);
    issue(OP_VALIDATE, 5'd18, '0);
    issue(OP_WRITE, 5'd5, 64'hA5A5_A5A5_5A5A_5A5A);
    issue(OP_CLEAR_COUNTS, 5'd5, '0);
    issue(OP_QUERY, 5'd5, '0);
    issue(OP_STATS, 5'd19, '0);
    issue(OP_RESET_ALL, 5'd0, '0);
    issue(OP_VALIDATE, 5'd0, '0);
    issue(OP_STATS, 5'd0, '0);
    drain();

    // validation and tracking off, every slot required
    program_config(1'b0, 1'b0, '1);
    issue(OP_WRITE, 5'd3, 64'h5555_AAAA_5555_AAAA);
    issue(OP_WRITE, 5'd3, 64'h5555_AAAA_5555_AAAA);
    issue(OP_VALIDATE, 5'd3, '0);
    issue(OP_QUERY, 5'd3, '0);
    drain();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: program_config(1'b1, 1'b1, '1);
        1: program_config(1'b1, 1'b1, '0);
        2: program_config(1'b0, 1'b1, pick_mask());
        3: program_config(1'b1, 1'b0, pick_mask());
        default: program_config(1'($urandom), 1'($urandom), pick_mask());
      endcase
      idle_on = (p % 3 != 1);
      phase_end = sent + 210;
      while (sent < phase_end) random_command();
      drain();
    end

    repeat (8) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("state_shadow_tracker_unit: match");
    end else begin
      $display("state_shadow_tracker_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("state_shadow_tracker_unit: mismatch");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/sst_pkg.sv
hw/rtl/sst_slot_table.sv
hw/rtl/state_shadow_tracker_unit.sv
bench/state_shadow_tracker_checker.sv
bench/testbench.sv
